/* src/nade_pkg.sv */
// package: widths, register indexes and size helpers for the energy map block
package nade_pkg;

  localparam int MaxWidth  = 4096;
  localparam int AddrW     = $clog2(MaxWidth);
  localparam int CntW      = 12;
  localparam int PixW      = 8;
  localparam int CfgW      = 13;
  localparam int CfgIdxW   = 1;
  localparam int EnergyW   = 11;
  localparam int PairW     = PixW + 1;
  localparam int OutFieldW = EnergyW + 2 * CntW;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // last index of a dimension: size clamped to 3..cap, minus one
  function automatic logic [CntW-1:0] last_index(input logic [CfgW-1:0] size,
                                                 input logic [CfgW-1:0] cap);
    logic [CfgW-1:0] s;
    s = size;
    if (s < CfgW'(3)) s = CfgW'(3);
    if (s > cap) s = cap;
    return CntW'(s - CfgW'(1));
  endfunction

  function automatic logic [PixW-1:0] abs_diff(input logic [PixW-1:0] a,
                                               input logic [PixW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

/* src/neighbor_abs_diff_energy_map.sv */
// top level: 3x3 neighbour absolute-difference energy over a raster pixel stream
//
// input channel (in_*): one 8-bit grayscale pixel per request, raster order,
// a new frame starting right after the last pixel of the previous one.
// result channel (out_*): one request per interior pixel carrying its energy
// (sum of the eight |neighbour - centre|), its row and column; tlast marks the
// final interior pixel of the frame. border pixels give no request.
// configuration: cfg_wen writes register cfg_index (0 width, 1 height) with
// cfg_wdata; user must write only while the block is idle (not enforced).
// throughput: one pixel per clock unless the result side stalls. the two
// previous rows sit in one synchronous line memory (both rows side by side in
// each word), read when a pixel is taken and written back as that pixel leaves
// stage 1, so the memory port pair sets the rate at one pixel per cycle.
// result path: the energy of pixel (r-1, c-1) is computed when pixel (r, c)
// arrives; it passes stage 1, stage 2 and the output register to out_tvalid.
// reset: counters and the window clear, width 640 and height 480; the line
// memory holds no reset value and needs no clearing pass (the first two rows
// of each frame write it before it is read for a result).
// stall: two pipeline stages plus the output register buffer the stream;
// while out_tready is low and the stages are full, in_tready falls.
module neighbor_abs_diff_energy_map (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [nade_pkg::PixW-1:0]   in_tdata,   // [7:0] pixel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [nade_pkg::OutDataW-1:0] out_tdata, // energy, row, column, zero pad
  output logic                        out_tlast,  // last_of_frame
  input  logic                        cfg_wen,
  input  logic [nade_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [nade_pkg::CfgW-1:0]   cfg_wdata
);
  import nade_pkg::*;

  // configuration
  logic [CfgW-1:0] width_r, height_r;
  logic [CntW-1:0] w_last, h_last;

  // position of the next pixel
  logic [CntW-1:0] row_r, col_r, row_nxt, col_nxt;

  // line memory: [2*PixW-1:PixW] row r-2, [PixW-1:0] row r-1
  logic [2*PixW-1:0] line_mem [MaxWidth];
  logic [2*PixW-1:0] rd_r;

  // stage 1: pixel with its memory read
  logic             s1_v_r;
  logic [PixW-1:0]  s1_pix_r;
  logic [AddrW-1:0] s1_addr_r;
  logic             s1_emit_r, s1_last_r;
  logic [CntW-1:0]  s1_row_r, s1_col_r;

  // 3x3 window: columns c-2 (0..2) and c-1 (3..5), top, middle, bottom
  logic [PixW-1:0]  win_r [6];

  // stage 2: pair sums of the absolute differences
  logic             s2_v_r;
  logic [PairW-1:0] s2_pair_r [4];
  logic [CntW-1:0]  s2_row_r, s2_col_r;
  logic             s2_last_r;

  // output register
  logic               out_v_r;
  logic [EnergyW-1:0] out_energy_r;
  logic [CntW-1:0]    out_row_r, out_col_r;
  logic               out_last_r;

  logic in_acc, s1_go, s2_free, out_adv;
  logic [PixW-1:0]  top, mid, ctr;
  logic [PixW-1:0]  ad [8];
  logic [PairW-1:0] pair [4];
  logic emit, last;

  assign w_last = last_index(width_r, CfgW'(MaxWidth));
  assign h_last = last_index(height_r, CfgW'(4096));

  // handshake chain: output register, stage 2, stage 1
  assign out_adv   = !out_v_r || out_tready;
  assign s2_free   = !s2_v_r || out_adv;
  assign s1_go     = s1_v_r && s2_free;
  assign in_tready = !s1_v_r || s2_free;
  assign in_acc    = in_tvalid && in_tready;

  // result of the arriving pixel's position
  assign emit = (row_r >= CntW'(2)) && (col_r >= CntW'(2)) &&
                (row_r <= h_last) && (col_r <= w_last);
  assign last = (row_r == h_last) && (col_r == w_last);

  always_comb begin
    if (col_r >= w_last) begin
      col_nxt = '0;
      row_nxt = (row_r >= h_last) ? '0 : row_r + CntW'(1);
    end else begin
      col_nxt = col_r + CntW'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CfgW'(640);
      height_r <= CfgW'(480);
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // memory: read on request, write back as stage 1 moves on (never the same
  // column as the read of that cycle, since consecutive pixels differ in column)
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= line_mem[col_r[AddrW-1:0]];
    end
    if (s1_go) begin
      line_mem[s1_addr_r] <= {mid, s1_pix_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_tdata;
      s1_addr_r <= col_r[AddrW-1:0];
      s1_emit_r <= emit;
      s1_last_r <= last;
      s1_row_r  <= row_r - CntW'(1);
      s1_col_r  <= col_r - CntW'(1);
    end
  end

  assign top = rd_r[2*PixW-1:PixW];
  assign mid = rd_r[PixW-1:0];
  assign ctr = win_r[4];

  always_comb begin
    ad[0] = abs_diff(win_r[0], ctr);
    ad[1] = abs_diff(win_r[1], ctr);
    ad[2] = abs_diff(win_r[2], ctr);
    ad[3] = abs_diff(win_r[3], ctr);
    ad[4] = abs_diff(win_r[5], ctr);
    ad[5] = abs_diff(top, ctr);
    ad[6] = abs_diff(mid, ctr);
    ad[7] = abs_diff(s1_pix_r, ctr);
    for (int i = 0; i < 4; i++) begin
      pair[i] = PairW'(ad[2*i]) + PairW'(ad[2*i+1]);
    end
  end

  // window shift as each pixel leaves stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_go) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_go && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s2_free) begin
      for (int i = 0; i < 4; i++) begin
        s2_pair_r[i] <= pair[i];
      end
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
      s2_last_r <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && out_adv) begin
      out_energy_r <= EnergyW'(s2_pair_r[0]) + EnergyW'(s2_pair_r[1]) +
                      EnergyW'(s2_pair_r[2]) + EnergyW'(s2_pair_r[3]);
      out_row_r    <= s2_row_r;
      out_col_r    <= s2_col_r;
      out_last_r   <= s2_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OutDataW - OutFieldW){1'b0}}, out_col_r, out_row_r, out_energy_r};

endmodule

/* sim/energy_map_checker.sv */
`timescale 1ns / 100ps
// checker: predicts the neighbour energy map from observed pixel requests and compares results
module energy_map_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [nade_pkg::PixW-1:0]      in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [nade_pkg::OutDataW-1:0]  out_tdata,
  input  logic                           out_tlast,
  input  logic                           cfg_wen,
  input  logic [nade_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [nade_pkg::CfgW-1:0]      cfg_wdata,
  output int                             fail_count,
  output int                             pending
);
  import nade_pkg::*;

  typedef struct packed {
    logic [EnergyW-1:0] energy;
    logic [CntW-1:0]    row;
    logic [CntW-1:0]    column;
    logic               last;
  } energy_result_t;

  logic [CfgW-1:0] width_reg;
  logic [CfgW-1:0] height_reg;
  logic [PixW-1:0] row_older [MaxWidth];
  logic [PixW-1:0] row_newer [MaxWidth];
  // columns c-2 and c-1, each as top, middle, bottom
  logic [PixW-1:0] win [6];
  int unsigned     row_at;
  int unsigned     col_at;
  int              errors = 0;
  energy_result_t  energy_q [$];

  task automatic take_pixel(input logic [PixW-1:0] bot);
    int unsigned w;
    int unsigned h;
    int unsigned ctr;
    int unsigned sum;
    int unsigned nb [8];
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    energy_result_t res;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MaxWidth) w = MaxWidth;
    h = height_reg;
    if (h < 3) h = 3;
    if (h > 4096) h = 4096;

    top = row_older[col_at];
    mid = row_newer[col_at];
    row_older[col_at] = mid;
    row_newer[col_at] = bot;

    // the arriving pixel completes the window of the pixel up and to the left
    if (row_at >= 2 && col_at >= 2 && row_at <= h - 1 && col_at <= w - 1) begin
      ctr = win[4];
      nb[0] = win[0]; nb[1] = win[1]; nb[2] = win[2]; nb[3] = win[3];
      nb[4] = win[5]; nb[5] = top;    nb[6] = mid;    nb[7] = bot;
      sum = 0;
      foreach (nb[k]) sum += (nb[k] > ctr) ? nb[k] - ctr : ctr - nb[k];
      res.energy = EnergyW'(sum);
      res.row    = CntW'(row_at - 1);
      res.column = CntW'(col_at - 1);
      res.last   = (row_at == h - 1) && (col_at == w - 1);
      energy_q.push_back(res);
    end

    win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
    win[3] = top;    win[4] = mid;    win[5] = bot;

    // a shrunk size mid-frame ends the row or frame at once
    if (col_at >= w - 1) begin
      col_at = 0;
      row_at = (row_at >= h - 1) ? 0 : ((row_at + 1) & 'hFFF);
    end else begin
      col_at = (col_at + 1) & 'hFFF;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    energy_result_t want;
    if (!rst_n) begin
      width_reg  = CfgW'(640);
      height_reg = CfgW'(480);
      foreach (win[k]) win[k] = '0;
      row_at = 0;
      col_at = 0;
      energy_q.delete();
    end else begin
      if (cfg_wen) begin
        if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_wdata;
        else if (cfg_index == REG_IMAGE_HEIGHT) height_reg = cfg_wdata;
      end
      if (in_tvalid && in_tready) take_pixel(in_tdata);
      if (out_tvalid && out_tready) begin
        if (energy_q.size() == 0) begin
          $error("result with nothing pending: tdata %h tlast %b", out_tdata, out_tlast);
          errors++;
        end else begin
          want = energy_q.pop_front();
          check_field("energy", 16'(want.energy), 16'(out_tdata[EnergyW-1:0]));
          check_field("row", 16'(want.row), 16'(out_tdata[EnergyW+CntW-1:EnergyW]));
          check_field("column", 16'(want.column),
                      16'(out_tdata[EnergyW+2*CntW-1:EnergyW+CntW]));
          check_field("last_of_frame", 16'(want.last), 16'(out_tlast));
        end
      end
    end
    pending    <= energy_q.size();
    fail_count <= errors;
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// testbench top: pixel stimulus, result back-pressure, configuration and verdict
module tb_top;
  import nade_pkg::*;

  // far above the slowest legal run: ~1000 pixels, each with a full gap and stall
  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned RandomItems = 550;
  // leave a margin after the last result before touching config
  localparam int unsigned DrainSlack  = 8;
  // widest frame that may run past its second row; wider ones start a fresh frame
  localparam int unsigned PrimeWidth  = 80;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [PixW-1:0]       in_tdata   = '0;   // [7:0] pixel
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OutDataW-1:0]   out_tdata;         // [10:0] energy, [22:11] row, [34:23] column
  logic                  out_tlast;         // last_of_frame
  logic                  cfg_wen    = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index  = '0;
  logic [CfgW-1:0]       cfg_wdata  = '0;

  int                    fail_count;
  int                    pending;
  int unsigned           cycle_count = 0;
  int unsigned           burst_left  = 0;
  int unsigned           hold_left   = 0;
  // steady: back-to-back pixel requests with no gaps
  bit                    steady      = 1'b0;
  // sizes as written and the position of the next pixel
  logic [CfgW-1:0]       width_now   = CfgW'(640);
  logic [CfgW-1:0]       height_now  = CfgW'(480);
  int unsigned           pos_row     = 0;
  int unsigned           pos_col     = 0;

  always #1 clk = ~clk;

  neighbor_abs_diff_energy_map uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  energy_map_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("neighbor_abs_diff_energy_map regression: fail");
      $finish;
    end
  end

  // result side: free-flowing stretches, hard stalls and cycle-by-cycle jitter
  always @(posedge clk) begin
    if (hold_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_tready <= 1'b1;
          hold_left = $urandom_range(20, 120);
        end
        1: begin
          out_tready <= 1'b0;
          hold_left = $urandom_range(1, 12);
        end
        default: begin
          out_tready <= 1'($urandom_range(0, 1));
          hold_left = 1;
        end
      endcase
    end else begin
      hold_left--;
    end
  end

  // size as the block sees it: clamped to 3..4096
  function automatic int unsigned eff_size(input logic [CfgW-1:0] size);
    int unsigned s;
    s = size;
    if (s < 3) s = 3;
    if (s > 4096) s = 4096;
    return s;
  endfunction

  // one pixel request; bursts of random length with random gaps between them
  task automatic send_pixel(input logic [PixW-1:0] p);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    do @(posedge clk); while (!in_tready);
    if (pos_col >= eff_size(width_now) - 1) begin
      pos_col = 0;
      pos_row = (pos_row >= eff_size(height_now) - 1) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endtask

  // hold off until every expected result has come and the pipeline is empty
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainSlack) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_now = val;
    else height_now = val;
  endtask

  // close the current frame through a 3 x 3 frame so the next pixel is the first
  task automatic restart_frame();
    write_reg(REG_IMAGE_WIDTH, CfgW'(3));
    write_reg(REG_IMAGE_HEIGHT, CfgW'(3));
    while (pos_row != 0 || pos_col != 0) send_pixel(8'($urandom));
    drain();
  endtask

  initial begin
    int unsigned     sent;
    int unsigned     phase;
    int unsigned     n;
    int unsigned     pix_mode;
    int unsigned     which;
    logic [PixW-1:0] p;
    logic [CfgW-1:0] w_new;
    logic [CfgW-1:0] h_new;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset height (480) on a narrow row: two full rows and a few pixels of
    // the third, then the height drops to 3 mid-frame so the third row closes it
    write_reg(REG_IMAGE_WIDTH, CfgW'(8));
    for (int i = 0; i < 2 * 8 + 5; i++) send_pixel(8'($urandom));
    drain();
    write_reg(REG_IMAGE_HEIGHT, CfgW'(3));
    for (int i = 0; i < 8 - 5; i++) send_pixel(8'($urandom));
    drain();

    // back-to-back frame at the prime width; afterwards every column that a
    // frame past its second row can reach holds written pixels
    write_reg(REG_IMAGE_WIDTH, CfgW'(PrimeWidth));
    steady = 1'b1;
    for (int i = 0; i < 3 * PrimeWidth; i++) send_pixel(8'($urandom));
    drain();
    steady = 1'b0;

    // smallest frame, hand-made windows: bright centre on black, dark centre
    // on white, and a ring of single-bit values around a bright centre
    write_reg(REG_IMAGE_WIDTH, CfgW'(3));
    for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 8'd255 : 8'd0);
    for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 8'd0 : 8'd255);
    for (int i = 0; i < 9; i++) send_pixel(i == 4 ? 8'd255 : 8'(1 << (i < 4 ? i : i - 1)));
    drain();

    // random phases: new size (often mid-frame), then a run of pixels
    sent  = 0;
    phase = 0;
    p     = 8'd128;
    while (sent < RandomItems) begin
      case (phase)
        // out-of-range sizes first: below 3 and above 4096 in both registers
        0: begin w_new = CfgW'(0);    h_new = CfgW'(1);    end
        1: begin w_new = CfgW'(8191); h_new = CfgW'(8191); end
        2: begin w_new = CfgW'(2);    h_new = CfgW'(2);    end
        3: begin w_new = CfgW'(4097); h_new = CfgW'(0);    end
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            w_new = CfgW'($urandom);
            h_new = CfgW'($urandom);
          end else if ($urandom_range(0, 7) == 0) begin
            w_new = CfgW'($urandom_range(17, 80));
            h_new = CfgW'($urandom_range(3, 10));
          end else begin
            w_new = CfgW'($urandom_range(3, 16));
            h_new = CfgW'($urandom_range(3, 10));
          end
        end
      endcase
      which = (phase < 4) ? 2 : $urandom_range(0, 3);
      // a wide row starts on a fresh frame so a run never passes its second row
      if (eff_size(which != 1 ? w_new : width_now) > PrimeWidth) restart_frame();
      if (which != 1) write_reg(REG_IMAGE_WIDTH, w_new);
      if (which != 0) write_reg(REG_IMAGE_HEIGHT, h_new);

      steady   = ($urandom_range(0, 3) == 0);
      pix_mode = $urandom_range(0, 3);
      n        = $urandom_range(20, 150);
      for (int i = 0; i < n; i++) begin
        case (pix_mode)
          0: p = 8'($urandom);
          1: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          // slowly varying picture, small energies
          2: p = 8'(p + $urandom_range(0, 6) - 3);
          default: p = 8'($urandom_range(100, 103));
        endcase
        send_pixel(p);
      end
      sent += n;
      // pause the sender until everything expected is out
      drain();
      phase++;
    end

    if (fail_count == 0) begin
      $display("neighbor_abs_diff_energy_map regression: pass");
    end else begin
      $display("neighbor_abs_diff_energy_map regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/nade_pkg.sv
src/neighbor_abs_diff_energy_map.sv
sim/energy_map_checker.sv
sim/tb_top.sv
